// ----- design/depq_pkg.sv -----
package depq_pkg;

    // Action codes carried by an input request
    localparam logic [1:0] ACT_INSERT   = 2'd0;
    localparam logic [1:0] ACT_POP_MIN  = 2'd1;
    localparam logic [1:0] ACT_POP_MAX  = 2'd2;

    // Status codes carried by a result request
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam int RESULT_WIDTH = 32;
    localparam int OCC_WIDTH    = 7;

    // Operation broadcast to every cell of the sorted chain
    typedef enum logic [1:0] {
        OP_NONE,
        OP_INSERT,
        OP_POP_MIN,
        OP_POP_MAX
    } op_t;

    typedef struct packed {
        logic fire;
        op_t  op;
    } cell_cmd_t;

endpackage

// ----- design/depq_in_if.sv -----
interface depq_in_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   action;
    logic signed [DATA_WIDTH-1:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink (input valid, input action, input value, output ready);
endinterface

// ----- design/depq_out_if.sv -----
interface depq_out_if;
    logic                                          valid;
    logic                                          ready;
    logic signed [depq_pkg::RESULT_WIDTH-1:0]      removed_value;
    logic [1:0]                                    status;
    logic [depq_pkg::OCC_WIDTH-1:0]                occupancy;

    modport source (output valid, output removed_value, output status, output occupancy,
                    input ready);
    modport sink (input valid, input removed_value, input status, input occupancy,
                  output ready);
endinterface

// ----- design/depq_cell.sv -----
// One slot of the sorted chain; slot 0 holds the smallest value.
module depq_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  depq_pkg::cell_cmd_t          cmd,
    input  logic signed [DATA_WIDTH-1:0] value,
    input  logic                         left_le,
    input  logic                         left_valid,
    input  logic signed [DATA_WIDTH-1:0] left_data,
    input  logic                         right_valid,
    input  logic signed [DATA_WIDTH-1:0] right_data,
    output logic                         le,
    output logic                         valid,
    output logic signed [DATA_WIDTH-1:0] data,
    output logic [DATA_WIDTH-1:0]        top_val
);

    logic                         valid_reg;
    logic                         valid_next;
    logic signed [DATA_WIDTH-1:0] data_reg;
    logic signed [DATA_WIDTH-1:0] data_next;
    logic                         is_top;

    // Flag whether this slot stays below the inserted value
    assign le     = valid_reg && (data_reg <= value);
    assign is_top = valid_reg && !right_valid;

    assign valid   = valid_reg;
    assign data    = data_reg;
    assign top_val = is_top ? data_reg : '0;

    // Keep, take the new value, or shift from a neighbour
    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (cmd.fire)
        begin
            case (cmd.op)
                depq_pkg::OP_INSERT:
                begin
                    valid_next = valid_reg | left_valid;
                    if (!le)
                    begin
                        data_next = left_le ? value : left_data;
                    end
                end
                depq_pkg::OP_POP_MIN:
                begin
                    valid_next = right_valid;
                    data_next  = right_data;
                end
                depq_pkg::OP_POP_MAX:
                begin
                    valid_next = valid_reg && !is_top;
                end
                default:
                begin
                    valid_next = valid_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// ----- design/double_ended_priority_queue.sv -----
// Channel  | Dir | Payload                              | Handshake
// in_ch    | in  | action[1:0], value[DATA_WIDTH-1:0]   | valid / ready
// out_ch   | out | removed_value[31:0], status, occ[6:0]| valid / ready
//
// Each request is first latched into the command register; then every cell of
// the sorted chain updates at once and the result register loads.
// A new request is taken while a result still waits; it then holds in the
// command register until the result register frees.
// Reset empties the chain by clearing the cell valid bits; no clearing pass.
// A stalled output holds its result and stalls the chain update.
module double_ended_priority_queue #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    depq_in_if.sink    in_ch,
    depq_out_if.source out_ch
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic                         exec_reg;
    logic                         exec_next;
    logic [1:0]                   action_reg;
    logic signed [DATA_WIDTH-1:0] value_reg;
    logic [CW-1:0]                count_reg;
    logic [CW-1:0]                count_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [depq_pkg::RESULT_WIDTH-1:0] removed_reg;
    logic [depq_pkg::RESULT_WIDTH-1:0] removed_next;
    logic [1:0]                   status_reg;
    logic [1:0]                   status_next;
    logic [depq_pkg::OCC_WIDTH-1:0] occ_reg;
    logic [depq_pkg::OCC_WIDTH-1:0] occ_next;

    logic                         in_fire;
    logic                         fire;
    logic                         full;
    logic                         empty;
    depq_pkg::cell_cmd_t          cmd;
    logic [DATA_WIDTH-1:0]        key;
    logic [DATA_WIDTH-1:0]        max_key;

    logic                         le_w    [CAPACITY];
    logic                         valid_w [CAPACITY];
    logic signed [DATA_WIDTH-1:0] data_w  [CAPACITY];
    logic [DATA_WIDTH-1:0]        top_w   [CAPACITY];

    assign in_ch.ready = !exec_reg;
    assign in_fire     = in_ch.valid && !exec_reg;
    assign fire        = exec_reg && (!out_valid_reg || out_ch.ready);
    assign full        = (count_reg == CW'(CAPACITY));
    assign empty       = (count_reg == '0);

    // Decode the held request into a chain operation and status
    always_comb
    begin
        cmd.fire    = fire;
        cmd.op      = depq_pkg::OP_NONE;
        status_next = depq_pkg::ST_DONE;
        count_next  = count_reg;
        case (action_reg)
            depq_pkg::ACT_INSERT:
            begin
                if (full)
                begin
                    status_next = depq_pkg::ST_FULL;
                end
                else
                begin
                    cmd.op     = depq_pkg::OP_INSERT;
                    count_next = count_reg + 1'b1;
                end
            end
            depq_pkg::ACT_POP_MIN, depq_pkg::ACT_POP_MAX:
            begin
                if (empty)
                begin
                    status_next = depq_pkg::ST_EMPTY;
                end
                else
                begin
                    cmd.op     = (action_reg == depq_pkg::ACT_POP_MIN) ?
                                 depq_pkg::OP_POP_MIN : depq_pkg::OP_POP_MAX;
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                cmd.op = depq_pkg::OP_NONE;
            end
        endcase
    end

    // Chain of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                         l_le;
        logic                         l_valid;
        logic signed [DATA_WIDTH-1:0] l_data;
        logic                         r_valid;
        logic signed [DATA_WIDTH-1:0] r_data;

        if (i == 0)
        begin : g_first
            assign l_le    = 1'b1;
            assign l_valid = 1'b1;
            assign l_data  = value_reg;
        end
        else
        begin : g_mid
            assign l_le    = le_w[i-1];
            assign l_valid = valid_w[i-1];
            assign l_data  = data_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign r_valid = 1'b0;
            assign r_data  = data_w[i];
        end
        else
        begin : g_inner
            assign r_valid = valid_w[i+1];
            assign r_data  = data_w[i+1];
        end

        depq_cell #(
            .DATA_WIDTH(DATA_WIDTH)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .value      (value_reg),
            .left_le    (l_le),
            .left_valid (l_valid),
            .left_data  (l_data),
            .right_valid(r_valid),
            .right_data (r_data),
            .le         (le_w[i]),
            .valid      (valid_w[i]),
            .data       (data_w[i]),
            .top_val    (top_w[i])
        );
    end

    // Gather the largest value from the single top cell
    always_comb
    begin
        max_key = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            max_key = max_key | top_w[i];
        end
    end

    always_comb
    begin
        key = '0;
        if (cmd.op == depq_pkg::OP_POP_MIN)
        begin
            key = data_w[0];
        end
        else if (cmd.op == depq_pkg::OP_POP_MAX)
        begin
            key = max_key;
        end
    end

    // Fit the removed value and occupancy to the result fields
    if (DATA_WIDTH >= depq_pkg::RESULT_WIDTH)
    begin : g_res_trunc
        assign removed_next = key[depq_pkg::RESULT_WIDTH-1:0];
    end
    else
    begin : g_res_ext
        assign removed_next = {{(depq_pkg::RESULT_WIDTH-DATA_WIDTH){1'b0}}, key};
    end

    if (CW >= depq_pkg::OCC_WIDTH)
    begin : g_occ_trunc
        assign occ_next = count_next[depq_pkg::OCC_WIDTH-1:0];
    end
    else
    begin : g_occ_ext
        assign occ_next = {{(depq_pkg::OCC_WIDTH-CW){1'b0}}, count_next};
    end

    // Hold a request until the result register frees
    always_comb
    begin
        exec_next = exec_reg;
        if (fire)
        begin
            exec_next = 1'b0;
        end
        else if (in_fire)
        begin
            exec_next = 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exec_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            exec_reg      <= exec_next;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Latch request and result payloads
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            action_reg <= in_ch.action;
            value_reg  <= in_ch.value;
        end
        if (fire)
        begin
            removed_reg <= removed_next;
            status_reg  <= status_next;
            occ_reg     <= occ_next;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.removed_value = removed_reg;
    assign out_ch.status        = status_reg;
    assign out_ch.occupancy     = occ_reg;

endmodule

// ----- design/depq_checker.sv -----
module depq_checker #(
    parameter int CAPACITY = 64
) (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   out_valid,
    input logic                                   out_ready,
    input logic [depq_pkg::RESULT_WIDTH-1:0]      removed_value,
    input logic [1:0]                             status,
    input logic [depq_pkg::OCC_WIDTH-1:0]         occupancy
);

    // A refused removal only happens on an empty queue and gives zero
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == depq_pkg::ST_EMPTY) |->
        (removed_value == '0 && occupancy == '0))
        else $error("empty status with non-zero value or occupancy");

    // A dropped insert only happens when full
    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == depq_pkg::ST_FULL) |->
        (occupancy == depq_pkg::OCC_WIDTH'(CAPACITY)))
        else $error("full status below capacity");

    // Status is never the unused code
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == depq_pkg::ST_DONE || status == depq_pkg::ST_EMPTY ||
                       status == depq_pkg::ST_FULL))
        else $error("unused status code");

    // A stalled result holds its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
        (out_valid && $stable(removed_value) && $stable(status) && $stable(occupancy)))
        else $error("result changed while stalled");

endmodule

bind double_ended_priority_queue depq_checker #(
    .CAPACITY(CAPACITY)
) u_depq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .removed_value(out_ch.removed_value),
    .status       (out_ch.status),
    .occupancy    (out_ch.occupancy)
);

// ----- test/depq_checker.sv -----
module depq_scoreboard #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    depq_in_if         in_ch,
    depq_out_if        out_ch,
    output int         fail_count,
    output int         pending_count
);

    typedef struct packed {
        logic signed [depq_pkg::RESULT_WIDTH-1:0] removed_value;
        logic [1:0]                               status;
        logic [depq_pkg::OCC_WIDTH-1:0]           occupancy;
    } depq_result_t;

    // Model contents as a plain multiset; removal order is what the sorted chain guarantees
    logic signed [DATA_WIDTH-1:0] stored_values[$];
    depq_result_t                 expected_results[$];

    function automatic depq_result_t apply_request(logic [1:0] action,
                                                   logic signed [DATA_WIDTH-1:0] value);
        depq_result_t r;
        int           pick;
        r = '0;
        pick = 0;
        if (action == depq_pkg::ACT_INSERT)
        begin
            if (stored_values.size() >= CAPACITY)
                r.status = depq_pkg::ST_FULL;
            else
                stored_values = {stored_values, value};
        end
        else if (action == depq_pkg::ACT_POP_MIN || action == depq_pkg::ACT_POP_MAX)
        begin
            if (stored_values.size() == 0)
                r.status = depq_pkg::ST_EMPTY;
            else
            begin
                for (int i = 1; i < stored_values.size(); i++)
                begin
                    if (action == depq_pkg::ACT_POP_MIN ?
                        stored_values[i] < stored_values[pick] :
                        stored_values[i] > stored_values[pick])
                        pick = i;
                end
                // Zero-extend a narrow word into the result field
                r.removed_value = depq_pkg::RESULT_WIDTH'($unsigned(stored_values[pick]));
                stored_values.delete(pick);
            end
        end
        r.occupancy = depq_pkg::OCC_WIDTH'(stored_values.size());
        return r;
    endfunction

    assign pending_count = expected_results.size();

    // Predict on each accepted request, compare each accepted result
    always @(posedge clk or negedge rst_n)
    begin
        depq_result_t want;
        depq_result_t got;
        if (!rst_n)
        begin
            fail_count <= 0;
            stored_values.delete();
            expected_results.delete();
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                expected_results = {expected_results,
                                    apply_request(in_ch.action, in_ch.value)};
            if (out_ch.valid && out_ch.ready)
            begin
                got = '{out_ch.removed_value, out_ch.status, out_ch.occupancy};
                if (expected_results.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result %p", got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: expected %p, got %p", want, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ----- test/double_ended_priority_queue_tb.sv -----
module double_ended_priority_queue_tb;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [1:0] ACT_SPARE = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending_count;
    int   cycle_count = 0;
    int   hold_off = 0;
    bit   stimulus_done = 1'b0;

    depq_in_if #(.DATA_WIDTH(DATA_WIDTH)) in_ch ();
    depq_out_if out_ch ();

    double_ended_priority_queue #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .out_ch(out_ch)
    );

    depq_scoreboard #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) checker_inst (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .fail_count   (fail_count),
        .pending_count(pending_count)
    );

    always #5 clk = ~clk;

    // Abort the run at a generous cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Stall the result side per result, with one long hold-off during the fill
    initial
    begin
        int wait_cycles;
        out_ch.ready = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            while (hold_off > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_off = hold_off - 1;
                @(negedge clk);
            end
            wait_cycles = $urandom_range(0, 3);
            if (wait_cycles > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (wait_cycles) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    function automatic logic signed [DATA_WIDTH-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return {1'b1, {(DATA_WIDTH-1){1'b0}}};
            1: return {1'b0, {(DATA_WIDTH-1){1'b1}}};
            2: return $signed(DATA_WIDTH'($urandom_range(0, 7)) - 4);
            default: return $signed(DATA_WIDTH'($urandom()));
        endcase
    endfunction

    // Offer one request, with a random gap first, and hold it until taken
    task automatic send_request(logic [1:0] action, logic signed [DATA_WIDTH-1:0] value,
                                bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.action <= action;
        in_ch.value  <= value;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        logic [1:0] act;
        int         roll;
        in_ch.valid  = 1'b0;
        in_ch.action = depq_pkg::ACT_INSERT;
        in_ch.value  = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: removals on empty, extremes, last-value removal, unused code
        send_request(depq_pkg::ACT_POP_MIN, '0, 0);
        send_request(depq_pkg::ACT_POP_MAX, '0, 0);
        send_request(depq_pkg::ACT_INSERT, {1'b1, {(DATA_WIDTH-1){1'b0}}}, 0);
        send_request(depq_pkg::ACT_POP_MIN, '0, 0);
        send_request(depq_pkg::ACT_INSERT, {1'b0, {(DATA_WIDTH-1){1'b1}}}, 0);
        send_request(depq_pkg::ACT_POP_MAX, '0, 0);
        send_request(depq_pkg::ACT_INSERT, '1, 1);
        send_request(depq_pkg::ACT_INSERT, '0, 1);
        send_request(ACT_SPARE, '1, 0);
        send_request(depq_pkg::ACT_POP_MAX, '0, 0);
        send_request(depq_pkg::ACT_POP_MIN, '0, 0);
        send_request(depq_pkg::ACT_POP_MIN, '0, 0);

        // Fill past capacity, starting while the result side holds off
        hold_off = 200;
        for (int i = 0; i < CAPACITY + 3; i++)
            send_request(depq_pkg::ACT_INSERT, pick_value(), 1);

        // Random mix, biased by phase towards filling or draining
        for (int i = 0; i < 680; i++)
        begin
            roll = $urandom_range(0, 99);
            if ((i / 100) % 2 == 0)
                act = roll < 60 ? depq_pkg::ACT_INSERT : (roll < 79 ? depq_pkg::ACT_POP_MIN
                    : (roll < 98 ? depq_pkg::ACT_POP_MAX : ACT_SPARE));
            else
                act = roll < 35 ? depq_pkg::ACT_INSERT : (roll < 66 ? depq_pkg::ACT_POP_MIN
                    : (roll < 98 ? depq_pkg::ACT_POP_MAX : ACT_SPARE));
            send_request(act, pick_value(), $urandom_range(0, 3) == 0);
        end
        in_ch.valid <= 1'b0;
        stimulus_done = 1'b1;
    end

    // Wait for the last result, let the block settle, then give the verdict
    initial
    begin
        wait (stimulus_done);
        while (pending_count != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
